// ----- src/csem_pkg.sv -----
// shared types and constants for the counting semaphore table
// no dependencies; imported by every module of the block
package csem_pkg;

    // fixed field widths of the words on both channels
    localparam int ID_FIELD_W = 5;
    localparam int VALUE_W    = 16;
    localparam int PID_W      = 5;

    // operation codes
    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_DESTROY = 2'd1,
        OP_WAIT    = 2'd2,
        OP_POST    = 2'd3
    } t_op;

    // status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // reset behavior of a ram instance
    localparam int RAM_CLEAR_NONE  = 0;
    localparam int RAM_CLEAR_ZERO  = 1;
    localparam int RAM_CLEAR_INDEX = 2;

    // input word
    typedef struct packed {
        t_op                   op;
        logic [ID_FIELD_W-1:0] sem_id;
        logic [VALUE_W-1:0]    init_value;
        logic [PID_W-1:0]      caller_pid;
    } t_in_word;

    // result word
    typedef struct packed {
        logic               status;
        logic [VALUE_W-1:0] result_value;
        logic               blocked;
        logic               woken_valid;
        logic [PID_W-1:0]   woken_pid;
    } t_out_word;

endpackage

// ----- src/csem_ram.sv -----
// single write port, single registered read port ram, write-first on a same-address hit
// optional per-entry valid bits make unwritten entries read as zero or as their index
// depends on csem_pkg
module csem_ram import csem_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int WIDTH      = 8,
    parameter int CLEAR_MODE = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;
    logic             bypass;

    assign bypass = i_we && (i_waddr == i_raddr);

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, new data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= bypass ? i_wdata : r_mem[i_raddr];
        end
    end

    generate
        if (CLEAR_MODE == RAM_CLEAR_NONE) begin : g_plain
            assign o_rdata = r_rdata;
        end else begin : g_clear
            logic [DEPTH-1:0]  r_valid;
            logic              r_rd_valid;
            logic [ADDR_W-1:0] r_rd_addr;

            // entry valid bits, cleared at once by reset
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid    <= '0;
                    r_rd_valid <= 1'b0;
                end else begin
                    if (i_we) begin
                        r_valid[i_waddr] <= 1'b1;
                    end
                    if (i_re) begin
                        r_rd_valid <= bypass || r_valid[i_raddr];
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_re) begin
                    r_rd_addr <= i_raddr;
                end
            end

            // unwritten entry reads as its reset value
            assign o_rdata = r_rd_valid ? r_rdata :
                             ((CLEAR_MODE == RAM_CLEAR_INDEX) ? WIDTH'(r_rd_addr) : '0);
        end
    endgenerate

endmodule

// ----- src/csem_free_fifo.sv -----
// fifo of free semaphore ids, reset holds every id in ascending order
// front id is a registered read taken at the head left by the current pop
// depends on csem_pkg, csem_ram
module csem_free_fifo import csem_pkg::*; #(
    parameter int NUM_SEMS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_pop,
    input  logic                        i_push,
    input  logic [$clog2(NUM_SEMS)-1:0] i_push_id,
    output logic [$clog2(NUM_SEMS)-1:0] o_front,
    output logic                        o_empty,
    output logic                        o_full
);

    localparam int SEM_W  = $clog2(NUM_SEMS);
    localparam int FILL_W = $clog2(NUM_SEMS + 1);
    localparam int SUM_W  = FILL_W + 1;

    logic [SEM_W-1:0]  r_head;
    logic [FILL_W-1:0] r_fill;
    logic [SEM_W-1:0]  n_head;
    logic [FILL_W-1:0] n_fill;
    logic [SUM_W-1:0]  tail_sum;
    logic [SEM_W-1:0]  tail;

    // head advance on pop, fill count follows pop and push
    always_comb begin
        n_head = r_head;
        if (i_pop) begin
            n_head = (r_head == SEM_W'(NUM_SEMS - 1)) ? '0 : r_head + 1'b1;
        end
        n_fill = r_fill + FILL_W'(i_push) - FILL_W'(i_pop);
    end

    // tail slot, head plus fill wrapped once
    assign tail_sum = SUM_W'(r_head) + SUM_W'(r_fill);
    assign tail     = (tail_sum >= SUM_W'(NUM_SEMS)) ?
                      SEM_W'(tail_sum - SUM_W'(NUM_SEMS)) : SEM_W'(tail_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= FILL_W'(NUM_SEMS);
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    csem_ram #(
        .DEPTH      (NUM_SEMS),
        .WIDTH      (SEM_W),
        .CLEAR_MODE (RAM_CLEAR_INDEX)
    ) u_id_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_push),
        .i_waddr (tail),
        .i_wdata (i_push_id),
        .i_re    (i_en),
        .i_raddr (n_head),
        .o_rdata (o_front)
    );

    assign o_empty = (r_fill == '0);
    assign o_full  = (r_fill == FILL_W'(NUM_SEMS));

endmodule

// ----- src/counting_semaphore_table_core.sv -----
// top level of the counting semaphore table: three register stages, the last the result register
// depends on csem_pkg, csem_ram, csem_free_fifo
//
// Takes one operation word per cycle while the result register is free (allocate,
// destroy, wait, post) and returns one result word per operation, in order. A word is
// accepted whenever the result register is empty or being taken, so with a ready
// consumer the rate is one word per cycle. The pipeline is shaped by two chained memory
// reads: the per-semaphore record (allocated flag, count, wait head, wait fill) is read
// at the accepting edge, the wait-queue memory entry at that semaphore's head is read as
// the word moves from stage 1 to stage 2, and the operation is decided in stage 2 and
// written back, together with the result register, as the word leaves stage 2; a word
// that follows one on the same semaphore sees its update through forwarding. The record
// and free-id memories take their reset values from per-entry valid bits, so the
// block is ready right after reset with no clearing pass. Free ids are handed out
// oldest first, starting with 0 to NUM_SEMS-1 in order.
module counting_semaphore_table_core import csem_pkg::*; #(
    parameter int NUM_SEMS    = 16,
    parameter int NUM_PROCS   = 32,
    parameter int WAIT_DEPTH  = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int SEM_W   = $clog2(NUM_SEMS);
    localparam int WD_W    = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int QFILL_W = $clog2(WAIT_DEPTH + 1);
    localparam int QSUM_W  = QFILL_W + 1;
    localparam int QDEPTH  = NUM_SEMS * WAIT_DEPTH;
    localparam int QADDR_W = $clog2(QDEPTH);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // per-semaphore record
    typedef struct packed {
        logic                   alloc;
        logic [COUNT_WIDTH-1:0] count;
        logic [WD_W-1:0]        head;
        logic [QFILL_W-1:0]     fill;
    } t_sem_rec;

    localparam int REC_W = $bits(t_sem_rec);

    logic             advance;
    logic             r_s1_valid;
    t_in_word         r_s1_word;
    logic             r_s2_valid;
    t_in_word         r_s2_word;
    t_sem_rec         r_s2_rec;
    logic             r_out_valid;
    t_out_word        r_out_word;

    logic [REC_W-1:0] rec_rd_bits;
    t_sem_rec         rec_rd;
    t_sem_rec         rec_fwd;
    logic [SEM_W-1:0] s1_idx;
    logic [SEM_W-1:0] s2_idx;

    logic [QADDR_W-1:0] q_raddr;
    logic [QADDR_W-1:0] q_waddr;
    logic [PID_W-1:0]   q_rdata;
    logic [QSUM_W-1:0]  q_tail_sum;
    logic [WD_W-1:0]    q_tail;

    logic [SEM_W-1:0] free_front;
    logic             free_empty;
    logic             free_full;

    logic             in_rng;
    logic             caller_ok;
    logic             sem_ok;
    t_out_word        s2_out;
    logic             s2_rec_we;
    logic [SEM_W-1:0] s2_widx;
    t_sem_rec         s2_wrec;
    logic             s2_q_we;
    logic             s2_pop;
    logic             s2_push;

    // whole pipeline moves when the result register is free or being taken
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = advance;

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= i_in_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_word  <= i_in_word;
            r_s2_word  <= r_s1_word;
            r_s2_rec   <= rec_fwd;
            r_out_word <= s2_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // record memory, read at the accepted word's id
    csem_ram #(
        .DEPTH      (NUM_SEMS),
        .WIDTH      (REC_W),
        .CLEAR_MODE (RAM_CLEAR_ZERO)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (advance && s2_rec_we),
        .i_waddr (s2_widx),
        .i_wdata (s2_wrec),
        .i_re    (advance),
        .i_raddr (SEM_W'(i_in_word.sem_id)),
        .o_rdata (rec_rd_bits)
    );

    assign rec_rd = t_sem_rec'(rec_rd_bits);

    // stage 1: take the update of the word just ahead
    assign s1_idx  = SEM_W'(r_s1_word.sem_id);
    assign rec_fwd = (s2_rec_we && (s2_widx == s1_idx)) ? s2_wrec : rec_rd;
    assign q_raddr = QADDR_W'(s1_idx) * QADDR_W'(WAIT_DEPTH) + QADDR_W'(rec_fwd.head);

    // wait queue memory, one queue of WAIT_DEPTH pids per semaphore
    csem_ram #(
        .DEPTH      (QDEPTH),
        .WIDTH      (PID_W),
        .CLEAR_MODE (RAM_CLEAR_NONE)
    ) u_wait_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (advance && s2_q_we),
        .i_waddr (q_waddr),
        .i_wdata (r_s2_word.caller_pid),
        .i_re    (advance),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    csem_free_fifo #(
        .NUM_SEMS (NUM_SEMS)
    ) u_free_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance),
        .i_pop     (advance && s2_pop),
        .i_push    (advance && s2_push),
        .i_push_id (s2_idx),
        .o_front   (free_front),
        .o_empty   (free_empty),
        .o_full    (free_full)
    );

    // stage 2 checks and queue tail slot
    assign s2_idx     = SEM_W'(r_s2_word.sem_id);
    assign in_rng     = (32'(r_s2_word.sem_id) < NUM_SEMS);
    assign caller_ok  = (32'(r_s2_word.caller_pid) < NUM_PROCS);
    assign sem_ok     = in_rng && r_s2_rec.alloc;
    assign q_tail_sum = QSUM_W'(r_s2_rec.head) + QSUM_W'(r_s2_rec.fill);
    assign q_tail     = (q_tail_sum >= QSUM_W'(WAIT_DEPTH)) ?
                        WD_W'(q_tail_sum - QSUM_W'(WAIT_DEPTH)) : WD_W'(q_tail_sum);
    assign q_waddr    = QADDR_W'(s2_idx) * QADDR_W'(WAIT_DEPTH) + QADDR_W'(q_tail);

    // stage 2: decide the operation, build the result and the write-back
    always_comb begin
        s2_out    = '0;
        s2_rec_we = 1'b0;
        s2_widx   = s2_idx;
        s2_wrec   = r_s2_rec;
        s2_q_we   = 1'b0;
        s2_pop    = 1'b0;
        s2_push   = 1'b0;
        unique case (r_s2_word.op)
            OP_ALLOC: begin
                if (free_empty) begin
                    s2_out.status = STATUS_ERR;
                end else begin
                    s2_widx             = free_front;
                    s2_wrec.alloc       = 1'b1;
                    s2_wrec.count       = COUNT_WIDTH'(r_s2_word.init_value);
                    s2_wrec.head        = '0;
                    s2_wrec.fill        = '0;
                    s2_rec_we           = 1'b1;
                    s2_pop              = 1'b1;
                    s2_out.result_value = VALUE_W'(free_front);
                end
            end
            OP_DESTROY: begin
                if (!sem_ok || (r_s2_rec.fill != '0)) begin
                    s2_out.status = STATUS_ERR;
                end else begin
                    s2_wrec.alloc = 1'b0;
                    s2_rec_we     = 1'b1;
                    s2_push       = !free_full;
                end
            end
            OP_WAIT: begin
                if (!sem_ok) begin
                    s2_out.status = STATUS_ERR;
                end else if (r_s2_rec.count != '0) begin
                    // take one unit
                    s2_wrec.count       = r_s2_rec.count - 1'b1;
                    s2_rec_we           = 1'b1;
                    s2_out.result_value = VALUE_W'(r_s2_rec.count - 1'b1);
                end else if ((r_s2_rec.fill == QFILL_W'(WAIT_DEPTH)) || !caller_ok) begin
                    s2_out.status = STATUS_ERR;
                end else begin
                    // queue the caller
                    s2_q_we        = 1'b1;
                    s2_wrec.fill   = r_s2_rec.fill + 1'b1;
                    s2_rec_we      = 1'b1;
                    s2_out.blocked = 1'b1;
                end
            end
            OP_POST: begin
                if (!sem_ok) begin
                    s2_out.status = STATUS_ERR;
                end else if (r_s2_rec.fill != '0) begin
                    // release the oldest waiter, count unchanged
                    s2_wrec.head = (r_s2_rec.head == WD_W'(WAIT_DEPTH - 1)) ?
                                   '0 : r_s2_rec.head + 1'b1;
                    s2_wrec.fill        = r_s2_rec.fill - 1'b1;
                    s2_rec_we           = 1'b1;
                    s2_out.woken_valid  = 1'b1;
                    s2_out.woken_pid    = q_rdata;
                    s2_out.result_value = VALUE_W'(r_s2_rec.count);
                end else begin
                    // add one unit, saturating
                    if (r_s2_rec.count != COUNT_MAX) begin
                        s2_wrec.count = r_s2_rec.count + 1'b1;
                    end
                    s2_rec_we           = 1'b1;
                    s2_out.result_value = VALUE_W'(s2_wrec.count);
                end
            end
        endcase
        // a bubble writes nothing
        if (!r_s2_valid) begin
            s2_rec_we = 1'b0;
            s2_q_we   = 1'b0;
            s2_pop    = 1'b0;
            s2_push   = 1'b0;
        end
    end

endmodule

// ----- src/csem_checker.sv -----
// port-level checks for the counting semaphore table, bound to the top level
// depends on csem_pkg and counting_semaphore_table_core
module csem_checker import csem_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // an error word carries nothing else
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == STATUS_ERR) |->
            (o_out_word.result_value == '0) && !o_out_word.blocked &&
            !o_out_word.woken_valid && (o_out_word.woken_pid == '0))
        else $error("error word with nonzero fields");

    // blocked and woken exclude each other, woken pid only with woken valid, a blocked word has value 0
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            !(o_out_word.blocked && o_out_word.woken_valid) &&
            (o_out_word.woken_valid || (o_out_word.woken_pid == '0)) &&
            (!o_out_word.blocked || (o_out_word.result_value == '0)))
        else $error("inconsistent blocked or woken fields");

    // an empty result register never holds off input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind counting_semaphore_table_core csem_checker u_csem_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

// ----- tb/counting_semaphore_table_core_test.sv -----
// self-checking testbench for counting_semaphore_table_core: directed table, then random traffic
// depends on csem_pkg and counting_semaphore_table_core; every result word is checked
// against a behavioral model of the semaphore table in this file, or against a directed row's result
module counting_semaphore_table_core_test import csem_pkg::*;;

    localparam int SEM_COUNT     = 16;
    localparam int PROC_COUNT    = 32;
    localparam int QUEUE_DEPTH   = 32;
    localparam int COUNT_W       = 16;
    localparam int ID_BITS       = $clog2(SEM_COUNT);
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int RANDOM_WORDS  = 1250;
    localparam int QUIET_LIMIT   = 4000;
    localparam int DIRECTED_ROWS = 24;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_word;

    counting_semaphore_table_core #(
        .NUM_SEMS    (SEM_COUNT),
        .NUM_PROCS   (PROC_COUNT),
        .WAIT_DEPTH  (QUEUE_DEPTH),
        .COUNT_WIDTH (COUNT_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // model of the semaphore table
    logic [ID_BITS-1:0]   free_ids   [SEM_COUNT];
    logic [ID_BITS-1:0]   free_head;
    logic [ID_BITS:0]     free_fill;
    logic                 live       [SEM_COUNT];
    logic [COUNT_W-1:0]   counts     [SEM_COUNT];
    logic [PID_W-1:0]     waiters    [SEM_COUNT][QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wait_head  [SEM_COUNT];
    logic [QPTR_BITS:0]   wait_fill  [SEM_COUNT];

    t_out_word expected_words [$];
    int        words_sent     = 0;
    int        fail_count     = 0;
    int        quiet_cycles   = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;

    // directed rows: stimulus, and the result where it is obvious
    typedef struct packed {
        t_op                op;
        logic [ID_FIELD_W-1:0] sem_id;
        logic [VALUE_W-1:0] init_value;
        logic [PID_W-1:0]   caller_pid;
        logic               typed;
        logic               status;
        logic [VALUE_W-1:0] value;
        logic               blocked;
        logic               woken;
        logic [PID_W-1:0]   woken_pid;
    } t_plan_row;

    t_plan_row directed_plan [DIRECTED_ROWS] = '{
        // bad ids right after reset
        '{OP_POST,    5'd0,  16'h0000, 5'd0,  1'b1, STATUS_ERR, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{OP_WAIT,    5'd31, 16'hFFFF, 5'd31, 1'b1, STATUS_ERR, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{OP_DESTROY, 5'd16, 16'h0000, 5'd0,  1'b1, STATUS_ERR, 16'h0000, 1'b0, 1'b0, 5'd0},
        // first ids come out in order
        '{OP_ALLOC,   5'd31, 16'h0000, 5'd0,  1'b1, STATUS_OK,  16'h0000, 1'b0, 1'b0, 5'd0},
        '{OP_ALLOC,   5'd0,  16'hFFFF, 5'd0,  1'b1, STATUS_OK,  16'h0001, 1'b0, 1'b0, 5'd0},
        // post at maximum count saturates
        '{OP_POST,    5'd1,  16'h0000, 5'd0,  1'b1, STATUS_OK,  16'hFFFF, 1'b0, 1'b0, 5'd0},
        '{OP_WAIT,    5'd1,  16'h0000, 5'd0,  1'b1, STATUS_OK,  16'hFFFE, 1'b0, 1'b0, 5'd0},
        // two waiters block, destroy is refused, posts wake them in order
        '{OP_WAIT,    5'd0,  16'h0000, 5'd31, 1'b1, STATUS_OK,  16'h0000, 1'b1, 1'b0, 5'd0},
        '{OP_WAIT,    5'd0,  16'hFFFF, 5'd0,  1'b1, STATUS_OK,  16'h0000, 1'b1, 1'b0, 5'd0},
        '{OP_DESTROY, 5'd0,  16'h0000, 5'd0,  1'b1, STATUS_ERR, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{OP_POST,    5'd0,  16'h0000, 5'd0,  1'b1, STATUS_OK,  16'h0000, 1'b0, 1'b1, 5'd31},
        '{OP_POST,    5'd0,  16'h0000, 5'd0,  1'b1, STATUS_OK,  16'h0000, 1'b0, 1'b1, 5'd0},
        '{OP_POST,    5'd0,  16'h0000, 5'd0,  1'b1, STATUS_OK,  16'h0001, 1'b0, 1'b0, 5'd0},
        '{OP_WAIT,    5'd0,  16'h0000, 5'd7,  1'b1, STATUS_OK,  16'h0000, 1'b0, 1'b0, 5'd0},
        // destroy an idle semaphore, then it is unallocated
        '{OP_DESTROY, 5'd0,  16'h0000, 5'd0,  1'b1, STATUS_OK,  16'h0000, 1'b0, 1'b0, 5'd0},
        '{OP_WAIT,    5'd0,  16'h0000, 5'd0,  1'b1, STATUS_ERR, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{OP_ALLOC,   5'd0,  16'h5555, 5'd0,  1'b1, STATUS_OK,  16'h0002, 1'b0, 1'b0, 5'd0},
        '{OP_ALLOC,   5'd0,  16'hAAAA, 5'd0,  1'b0, STATUS_OK,  16'h0000, 1'b0, 1'b0, 5'd0},
        '{OP_POST,    5'd3,  16'h0000, 5'd0,  1'b0, STATUS_OK,  16'h0000, 1'b0, 1'b0, 5'd0},
        '{OP_DESTROY, 5'd1,  16'h0000, 5'd0,  1'b1, STATUS_OK,  16'h0000, 1'b0, 1'b0, 5'd0},
        '{OP_WAIT,    5'd2,  16'h0000, 5'd21, 1'b0, STATUS_OK,  16'h0000, 1'b0, 1'b0, 5'd0},
        '{OP_DESTROY, 5'd2,  16'h0000, 5'd0,  1'b0, STATUS_OK,  16'h0000, 1'b0, 1'b0, 5'd0},
        '{OP_POST,    5'd15, 16'h0000, 5'd0,  1'b1, STATUS_ERR, 16'h0000, 1'b0, 1'b0, 5'd0},
        '{OP_ALLOC,   5'd9,  16'h0001, 5'd0,  1'b0, STATUS_OK,  16'h0000, 1'b0, 1'b0, 5'd0}
    };

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // apply one operation to the model and return its result word
    function automatic t_out_word semaphore_outcome(input t_in_word w);
        t_out_word r;
        int        id;
        r  = '0;
        id = int'(w.sem_id);
        if (w.op == OP_ALLOC) begin
            if (free_fill == 0) begin
                r.status = STATUS_ERR;
                return r;
            end
            id            = int'(free_ids[free_head]);
            free_head     = free_head + 1'b1;
            free_fill     = free_fill - 1'b1;
            live[id]      = 1'b1;
            counts[id]    = w.init_value[COUNT_W-1:0];
            wait_head[id] = '0;
            wait_fill[id] = '0;
            r.result_value = VALUE_W'(id);
            return r;
        end
        if (id >= SEM_COUNT || !live[id]) begin
            r.status = STATUS_ERR;
            return r;
        end
        case (w.op)
            OP_DESTROY: begin
                if (wait_fill[id] != 0) begin
                    r.status = STATUS_ERR;
                end else begin
                    live[id] = 1'b0;
                    if (free_fill < SEM_COUNT) begin
                        free_ids[ID_BITS'(free_head + free_fill)] = ID_BITS'(id);
                        free_fill = free_fill + 1'b1;
                    end
                end
            end
            OP_WAIT: begin
                if (counts[id] != 0) begin
                    counts[id]     = counts[id] - 1'b1;
                    r.result_value = VALUE_W'(counts[id]);
                end else if (wait_fill[id] >= QUEUE_DEPTH || int'(w.caller_pid) >= PROC_COUNT) begin
                    r.status = STATUS_ERR;
                end else begin
                    waiters[id][QPTR_BITS'(wait_head[id] + wait_fill[id])] = w.caller_pid;
                    wait_fill[id] = wait_fill[id] + 1'b1;
                    r.blocked     = 1'b1;
                end
            end
            default: begin
                // post: wake the oldest waiter, else count up to saturation
                if (wait_fill[id] != 0) begin
                    r.woken_valid = 1'b1;
                    r.woken_pid   = waiters[id][wait_head[id]];
                    wait_head[id] = wait_head[id] + 1'b1;
                    wait_fill[id] = wait_fill[id] - 1'b1;
                end else if (counts[id] != '1) begin
                    counts[id] = counts[id] + 1'b1;
                end
                r.result_value = VALUE_W'(counts[id]);
            end
        endcase
        return r;
    endfunction

    function automatic t_in_word make_word(input t_op op, input int id, input int init,
                                           input int pid);
        t_in_word w;
        w.op         = op;
        w.sem_id     = ID_FIELD_W'(id);
        w.init_value = VALUE_W'(init);
        w.caller_pid = PID_W'(pid);
        return w;
    endfunction

    // random allocated id; returns 0 and a random table id when none is allocated
    function automatic bit pick_live(output int id);
        int found [$];
        for (int s = 0; s < SEM_COUNT; s++)
            if (live[s]) found.push_back(s);
        if (found.size() == 0) begin
            id = $urandom_range(0, SEM_COUNT - 1);
            return 1'b0;
        end
        id = found[$urandom_range(0, found.size() - 1)];
        return 1'b1;
    endfunction

    // initial count: mostly tiny, sometimes anything, sometimes near the top
    function automatic int pick_init();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) return $urandom_range(0, 3);
        if (roll < 8) return $urandom_range(0, 65535);
        return $urandom_range(65532, 65535);
    endfunction

    // drive one word, wait for its handshake, record its expected result
    task automatic send_word(input t_in_word w, input logic has_given, input t_out_word given,
                             output t_out_word outcome);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        outcome = semaphore_outcome(w);
        expected_words.push_back(has_given ? given : outcome);
        words_sent++;
    endtask

    // hold off the sender until every result word is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_words.size() != 0);
    endtask

    // one random sequence of operations
    task automatic run_sequence();
        int        kind;
        int        id;
        int        n;
        int        roll;
        t_out_word got;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            // mixed traffic on live semaphores
            n = $urandom_range(6, 20);
            repeat (n) begin
                if (!pick_live(id) || $urandom_range(0, 9) == 0) begin
                    send_word(make_word(OP_ALLOC, $urandom_range(0, 31), pick_init(),
                              $urandom_range(0, 31)), 1'b0, '0, got);
                end else begin
                    roll = $urandom_range(0, 19);
                    send_word(make_word(roll < 2 ? OP_DESTROY : (roll < 11 ? OP_WAIT : OP_POST),
                              id, $urandom_range(0, 65535), $urandom_range(0, 31)),
                              1'b0, '0, got);
                end
            end
        end else if (kind < 52) begin
            // fill a wait queue, possibly past full, then release waiters
            send_word(make_word(OP_ALLOC, $urandom_range(0, 31), $urandom_range(0, 2),
                      $urandom_range(0, 31)), 1'b0, '0, got);
            if (got.status == STATUS_OK) id = int'(got.result_value);
            else void'(pick_live(id));
            n = $urandom_range(1, QUEUE_DEPTH + 4);
            repeat (n)
                send_word(make_word(OP_WAIT, id, $urandom_range(0, 65535),
                          $urandom_range(0, 31)), 1'b0, '0, got);
            if ($urandom_range(0, 3) == 0)
                send_word(make_word(OP_DESTROY, id, 0, 0), 1'b0, '0, got);
            repeat ($urandom_range(0, n + 2))
                send_word(make_word(OP_POST, id, $urandom_range(0, 65535),
                          $urandom_range(0, 31)), 1'b0, '0, got);
            if ($urandom_range(0, 1) == 0)
                send_word(make_word(OP_DESTROY, id, 0, 0), 1'b0, '0, got);
        end else if (kind < 62) begin
            // allocate until the free list runs dry, then give some back
            do begin
                send_word(make_word(OP_ALLOC, $urandom_range(0, 31), pick_init(),
                          $urandom_range(0, 31)), 1'b0, '0, got);
            end while (got.status == STATUS_OK);
            repeat ($urandom_range(1, 10)) begin
                void'(pick_live(id));
                send_word(make_word(OP_DESTROY, id, $urandom_range(0, 65535),
                          $urandom_range(0, 31)), 1'b0, '0, got);
            end
        end else if (kind < 72) begin
            // counts near the top, posts saturate
            send_word(make_word(OP_ALLOC, 0, $urandom_range(65532, 65535), 0), 1'b0, '0, got);
            if (got.status == STATUS_OK) id = int'(got.result_value);
            else void'(pick_live(id));
            repeat ($urandom_range(1, 6))
                send_word(make_word(OP_POST, id, 0, $urandom_range(0, 31)), 1'b0, '0, got);
            repeat ($urandom_range(1, 3))
                send_word(make_word(OP_WAIT, id, 0, $urandom_range(0, 31)), 1'b0, '0, got);
        end else if (kind < 84) begin
            // noise: every field random
            repeat ($urandom_range(3, 10))
                send_word(make_word(t_op'($urandom_range(0, 3)), $urandom_range(0, 31),
                          $urandom_range(0, 65535), $urandom_range(0, 31)), 1'b0, '0, got);
        end else begin
            // ids beyond the table or random ids within it
            repeat ($urandom_range(2, 6)) begin
                id = $urandom_range(0, 1) ? $urandom_range(SEM_COUNT, 31)
                                          : $urandom_range(0, SEM_COUNT - 1);
                send_word(make_word(t_op'($urandom_range(1, 3)), id, $urandom_range(0, 65535),
                          $urandom_range(0, 31)), 1'b0, '0, got);
            end
        end
    endtask

    // receiver stalls
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // result check and activity watch
    always @(posedge i_clk) begin : result_check
        t_out_word want;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                $error("result word %h with nothing expected", o_out_word);
                fail_count++;
            end else begin
                want = expected_words.pop_front();
                if (o_out_word.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_word.status);
                    fail_count++;
                end
                if (o_out_word.result_value !== want.result_value) begin
                    $error("result_value: expected %0d, got %0d",
                           want.result_value, o_out_word.result_value);
                    fail_count++;
                end
                if (o_out_word.blocked !== want.blocked) begin
                    $error("blocked: expected %0d, got %0d", want.blocked, o_out_word.blocked);
                    fail_count++;
                end
                if (o_out_word.woken_valid !== want.woken_valid) begin
                    $error("woken_valid: expected %0d, got %0d",
                           want.woken_valid, o_out_word.woken_valid);
                    fail_count++;
                end
                if (o_out_word.woken_pid !== want.woken_pid) begin
                    $error("woken_pid: expected %0d, got %0d",
                           want.woken_pid, o_out_word.woken_pid);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        t_plan_row row;
        t_out_word got;
        int        random_start;
        for (int s = 0; s < SEM_COUNT; s++) begin
            free_ids[s]  = ID_BITS'(s);
            live[s]      = 1'b0;
            counts[s]    = '0;
            wait_head[s] = '0;
            wait_fill[s] = '0;
        end
        free_head = '0;
        free_fill = (ID_BITS + 1)'(SEM_COUNT);

        send_idle_pct  = 11;
        recv_stall_pct = 54;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (directed_plan[k]) begin
            row = directed_plan[k];
            send_word(make_word(row.op, row.sem_id, row.init_value, row.caller_pid), row.typed,
                      {row.status, row.value, row.blocked, row.woken, row.woken_pid}, got);
        end

        // random traffic in three idling phases, drained between them
        random_start = words_sent;
        for (int phase = 0; phase < 3; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    send_idle_pct  = 11;
                    recv_stall_pct = 54;
                end
                1: begin
                    send_idle_pct  = 54;
                    recv_stall_pct = 11;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            while (words_sent < random_start + (phase + 1) * RANDOM_WORDS / 3)
                run_sequence();
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
